/* hdl/mpa_pkg.sv */
// mpa_pkg: shared types and constants for the median price aggregator
// depends on nothing
package mpa_pkg;
    localparam int MaxPub = 32;
    localparam int IdxW = $clog2(MaxPub);
    localparam int CntW = 6;

    typedef enum logic [1:0] {
        KIND_POST = 2'd0,
        KIND_AGG  = 2'd1,
        KIND_ADD  = 2'd2,
        KIND_DEL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OUT_OK      = 3'd0,
        OUT_ZERO_ID = 3'd1,
        OUT_UNKNOWN = 3'd2,
        OUT_DUP     = 3'd3,
        OUT_FULL    = 3'd4
    } outcome_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] id;
        logic [63:0] price;
        logic [63:0] conf;
        logic [7:0]  status;
        logic [63:0] slot;
    } item_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [63:0] price;
        logic [63:0] conf;
        logic        trading;
        logic [63:0] pub_slot;
        logic [63:0] val_slot;
        logic [5:0]  count;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_DECIDE,
        ST_SCAN,
        ST_INS,
        ST_PICK,
        ST_PICK2,
        ST_AVG,
        ST_WRITE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // signed average, exact sum, truncated toward zero
    function automatic logic [63:0] avg_signed(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [64:0] h;
        s = {a[63], a} + {b[63], b};
        h = {s[64], s[64:1]};
        if (s[64] && s[0])
            h = h + 65'd1;
        return h[63:0];
    endfunction
endpackage

/* hdl/median_price_aggregator.sv */
// median_price_aggregator: top level with configuration port
// depends on mpa_pkg, mpa_front, mpa_engine
//
// usage:
//   input channel: push/full, one transfer per item (kind, publisher_id,
//   quote fields, current_slot_in); a two-entry queue takes items while
//   the engine works
//   result channel: empty/pop; one result per item, held until popped
//   apb port: register 0 at address 0 is trading_status_code, reset 1
// operation: the engine looks up the id one entry per cycle (up to 32),
// then an aggregation scans the table and insertion-sorts eligible
// quotes one compare per cycle, a delete moves one entry per cycle
// reset: table empty, aggregate zero, not trading
// while the result waits unpopped the engine takes no new item; the
// input queue still accepts up to two
module median_price_aggregator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [63:0] publisher_id,
    input  logic signed [63:0] quote_price,
    input  logic [63:0] quote_conf,
    input  logic [7:0]  quote_status,
    input  logic [63:0] current_slot_in,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  outcome,
    output logic signed [63:0] agg_price,
    output logic [63:0] agg_conf,
    output logic        agg_trading,
    output logic [63:0] agg_publish_slot,
    output logic [63:0] agg_valid_slot,
    output logic [5:0]  publisher_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mpa_pkg::*;

    item_t   in_item;
    item_t   q_item;
    result_t res;
    logic    avail;
    logic    take;
    logic [7:0] code_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, code_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_reg <= 8'd1;
        else if (psel && penable && pwrite && paddr == 2'd0)
            code_reg <= pwdata[7:0];
    end

    assign in_item.kind = kind_t'(kind);
    assign in_item.id = publisher_id;
    assign in_item.price = quote_price;
    assign in_item.conf = quote_conf;
    assign in_item.status = quote_status;
    assign in_item.slot = current_slot_in;

    mpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item_in  (in_item),
        .take     (take),
        .avail    (avail),
        .item_out (q_item)
    );

    mpa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .trade_code (code_reg),
        .avail      (avail),
        .take       (take),
        .item       (q_item),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign outcome = res.outcome;
    assign agg_price = res.price;
    assign agg_conf = res.conf;
    assign agg_trading = res.trading;
    assign agg_publish_slot = res.pub_slot;
    assign agg_valid_slot = res.val_slot;
    assign publisher_count = res.count;
endmodule

/* hdl/mpa_front.sv */
// mpa_front: input queue that holds items for the engine
// depends on mpa_pkg
module mpa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  mpa_pkg::item_t       item_in,
    input  logic                 take,
    output logic                 avail,
    output mpa_pkg::item_t       item_out
);
    import mpa_pkg::*;

    item_t     q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       wr;
    logic       rd;

    assign full = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign item_out = q_reg[rp_reg];
    assign wr = push && !full;
    assign rd = take && avail;

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wp_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd0) |-> !rd)
        else $error("read from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("count did not advance");
endmodule

/* hdl/mpa_engine.sv */
// mpa_engine: table, sequencer, insertion sort and result register
// depends on mpa_pkg
module mpa_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           trade_code,
    input  logic                 avail,
    output logic                 take,
    input  mpa_pkg::item_t       item,
    output logic                 empty,
    input  logic                 pop,
    output mpa_pkg::result_t     res
);
    import mpa_pkg::*;

    logic [63:0] ids_reg    [MaxPub];
    logic [63:0] price_reg  [MaxPub];
    logic [63:0] conf_reg   [MaxPub];
    logic [7:0]  stat_reg   [MaxPub];
    logic [63:0] slot_reg   [MaxPub];
    logic [IdxW-1:0] ord_reg [MaxPub];

    state_t state_reg, state_next;
    item_t  cur_reg;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] i_reg;
    logic [CntW-1:0] n_reg;
    logic [CntW-1:0] j_reg;
    logic            hit_reg;
    logic [IdxW-1:0] idx_reg;
    logic [63:0] accum_reg, vslot_reg, pslot_reg, mprice_reg, mconf_reg;
    logic        mvalid_reg;
    logic [63:0] pa_reg, ca_reg;
    outcome_t    oc_reg;
    result_t     res_reg;
    logic        full_reg;

    logic [IdxW-1:0] ii;
    logic [IdxW-1:0] jj;
    logic [IdxW-1:0] jm;
    logic [IdxW-1:0] mi;
    logic            ins_move;

    assign ii = i_reg[IdxW-1:0];
    assign jj = j_reg[IdxW-1:0];
    assign jm = jj - 1'b1;
    assign mi = n_reg[IdxW:1];
    assign ins_move = (j_reg != '0)
        && ($signed(price_reg[ord_reg[jm]]) > $signed(price_reg[ii]));
    assign empty = !full_reg;
    assign res = res_reg;
    assign take = (state_reg == ST_IDLE) && avail && !full_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (take) state_next = ST_FIND;
            ST_FIND:
                if (hit_reg || i_reg >= cnt_reg) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                if (cur_reg.kind inside {KIND_POST, KIND_AGG})
                begin
                    if (hit_reg && cur_reg.slot > accum_reg) state_next = ST_SCAN;
                    else if (hit_reg && cur_reg.kind == KIND_POST) state_next = ST_WRITE;
                end
                else if (cur_reg.id != '0)
                begin
                    if (cur_reg.kind == KIND_ADD && !hit_reg && cnt_reg < CntW'(MaxPub))
                        state_next = ST_WRITE;
                    else if (cur_reg.kind == KIND_DEL && hit_reg)
                        state_next = ST_SHIFT;
                end
            end
            ST_SCAN:
                if (i_reg >= cnt_reg)
                    state_next = (n_reg == '0) ? ST_WRITE : ST_PICK;
                else if (stat_reg[ii] == trade_code && slot_reg[ii] == cur_reg.slot - 64'd1)
                    state_next = ST_INS;
            ST_INS:    if (!ins_move) state_next = ST_SCAN;
            ST_PICK:   state_next = (!n_reg[0]) ? ST_PICK2 : ST_WRITE;
            ST_PICK2:  state_next = ST_AVG;
            ST_AVG:    state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_DONE;
            ST_SHIFT:  if (i_reg + 1'b1 >= cnt_reg) state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // table and datapath, one entry per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    cur_reg <= item;
                    i_reg <= '0;
                    hit_reg <= 1'b0;
                end
            ST_FIND:
                if (!hit_reg && i_reg < cnt_reg)
                begin
                    if (ids_reg[ii] == cur_reg.id)
                    begin
                        hit_reg <= 1'b1;
                        idx_reg <= ii;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
            ST_DECIDE:
            begin
                i_reg <= (cur_reg.kind == KIND_DEL) ? {1'b0, idx_reg} : '0;
                n_reg <= '0;
                if (cur_reg.kind inside {KIND_POST, KIND_AGG})
                    oc_reg <= hit_reg ? OUT_OK : OUT_UNKNOWN;
                else if (cur_reg.id == '0)
                    oc_reg <= OUT_ZERO_ID;
                else if (cur_reg.kind == KIND_DEL)
                    oc_reg <= hit_reg ? OUT_OK : OUT_UNKNOWN;
                else if (hit_reg)
                    oc_reg <= OUT_DUP;
                else if (cnt_reg >= CntW'(MaxPub))
                    oc_reg <= OUT_FULL;
                else
                begin
                    oc_reg <= OUT_OK;
                    idx_reg <= cnt_reg[IdxW-1:0];
                end
            end
            ST_SCAN:
                if (i_reg < cnt_reg)
                begin
                    if (stat_reg[ii] == trade_code && slot_reg[ii] == cur_reg.slot - 64'd1)
                        j_reg <= n_reg;
                    else
                        i_reg <= i_reg + 1'b1;
                end
            ST_INS:
                if (ins_move)
                begin
                    ord_reg[jj] <= ord_reg[jm];
                    j_reg <= j_reg - 1'b1;
                end
                else
                begin
                    ord_reg[jj] <= ii;
                    n_reg <= n_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                end
            ST_PICK2:
            begin
                pa_reg <= price_reg[ord_reg[mi - 1'b1]];
                ca_reg <= conf_reg[ord_reg[mi - 1'b1]];
            end
            ST_WRITE:
                if (cur_reg.kind == KIND_ADD)
                begin
                    ids_reg[idx_reg] <= cur_reg.id;
                    price_reg[idx_reg] <= '0;
                    conf_reg[idx_reg] <= '0;
                    stat_reg[idx_reg] <= '0;
                    slot_reg[idx_reg] <= '0;
                end
                else if (cur_reg.kind == KIND_POST)
                begin
                    price_reg[idx_reg] <= cur_reg.price;
                    conf_reg[idx_reg] <= cur_reg.conf;
                    stat_reg[idx_reg] <= cur_reg.status;
                    slot_reg[idx_reg] <= cur_reg.slot;
                end
            ST_SHIFT:
                if (i_reg + 1'b1 < cnt_reg)
                begin
                    ids_reg[ii] <= ids_reg[ii + 1'b1];
                    price_reg[ii] <= price_reg[ii + 1'b1];
                    conf_reg[ii] <= conf_reg[ii + 1'b1];
                    stat_reg[ii] <= stat_reg[ii + 1'b1];
                    slot_reg[ii] <= slot_reg[ii + 1'b1];
                    i_reg <= i_reg + 1'b1;
                end
            default: ;
        endcase
    end

    // aggregate state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            accum_reg <= '0;
            vslot_reg <= '0;
            pslot_reg <= '0;
            mvalid_reg <= 1'b0;
            full_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            if (pop && full_reg)
                full_reg <= 1'b0;
            if (state_reg == ST_SCAN && i_reg >= cnt_reg)
            begin
                pslot_reg <= cur_reg.slot;
                vslot_reg <= accum_reg;
                accum_reg <= cur_reg.slot;
                mvalid_reg <= (n_reg != '0);
            end
            if (state_reg == ST_WRITE && cur_reg.kind == KIND_ADD)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == ST_SHIFT && i_reg + 1'b1 >= cnt_reg)
                cnt_reg <= cnt_reg - 1'b1;
            if (state_reg == ST_DONE)
            begin
                full_reg <= 1'b1;
                res_reg.outcome <= oc_reg;
                res_reg.price <= mprice_reg;
                res_reg.conf <= mconf_reg;
                res_reg.trading <= mvalid_reg;
                res_reg.pub_slot <= pslot_reg;
                res_reg.val_slot <= vslot_reg;
                res_reg.count <= cnt_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mprice_reg <= '0;
            mconf_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_PICK)
            begin
                mprice_reg <= price_reg[ord_reg[mi]];
                mconf_reg <= conf_reg[ord_reg[mi]];
            end
            else if (state_reg == ST_AVG)
            begin
                mprice_reg <= avg_signed(mprice_reg, pa_reg);
                mconf_reg <= (mconf_reg & ca_reg) + ((mconf_reg ^ ca_reg) >> 1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CntW'(MaxPub))
        else $error("publisher count beyond table");
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_DONE) |=> full_reg)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n) take |-> !full_reg)
        else $error("item taken while result waits");
endmodule

/* tb/tb_median_price_aggregator.sv */
`timescale 1ns / 1ps
// tb_median_price_aggregator: testbench for the median price aggregator
// holds its own table model, random item driver, result monitor and apb writes
// depends on mpa_pkg and median_price_aggregator
module tb_median_price_aggregator;
    import mpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  kind;
    logic [63:0] publisher_id;
    logic signed [63:0] quote_price;
    logic [63:0] quote_conf;
    logic [7:0]  quote_status;
    logic [63:0] current_slot_in;
    logic        empty;
    logic        pop;
    logic [2:0]  outcome;
    logic signed [63:0] agg_price;
    logic [63:0] agg_conf;
    logic        agg_trading;
    logic [63:0] agg_publish_slot;
    logic [63:0] agg_valid_slot;
    logic [5:0]  publisher_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [1:0] ADDR_TRADING = 2'd0;
    localparam int CYCLE_LIMIT = 1500000;

    median_price_aggregator dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .publisher_id(publisher_id), .quote_price(quote_price),
        .quote_conf(quote_conf), .quote_status(quote_status),
        .current_slot_in(current_slot_in), .empty(empty), .pop(pop),
        .outcome(outcome), .agg_price(agg_price), .agg_conf(agg_conf),
        .agg_trading(agg_trading), .agg_publish_slot(agg_publish_slot),
        .agg_valid_slot(agg_valid_slot), .publisher_count(publisher_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model state
    logic [63:0] tbl_id [MaxPub];
    logic [63:0] tbl_price [MaxPub];
    logic [63:0] tbl_conf [MaxPub];
    logic [7:0]  tbl_status [MaxPub];
    logic [63:0] tbl_slot [MaxPub];
    int          tbl_count;
    logic [63:0] m_accum;
    logic [63:0] m_valid_slot;
    logic [63:0] m_pub_slot;
    logic [63:0] m_price;
    logic [63:0] m_conf;
    logic        m_trading;
    logic [7:0]  m_trading_code;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      mismatches;
    int      cycle_count;
    int      accepted_items;

    always #1 clk = ~clk;

    function automatic int find_id(logic [63:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void run_median(logic [63:0] slot);
        int order[MaxPub];
        int n;
        int j;
        int m;
        logic [64:0] s;
        logic [63:0] h;
        logic [63:0] ca;
        n = 0;
        m_pub_slot = slot;
        m_valid_slot = m_accum;
        m_accum = slot;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_status[i] == m_trading_code && tbl_slot[i] == slot - 64'd1) begin
                j = n;
                n++;
                while (j > 0 && $signed(tbl_price[order[j-1]]) > $signed(tbl_price[i])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
        end
        if (n == 0) begin
            m_trading = 1'b0;
            return;
        end
        m = n / 2;
        m_price = tbl_price[order[m]];
        m_conf = tbl_conf[order[m]];
        if (m > 0 && n % 2 == 0) begin
            s = $signed({m_price[63], m_price}) + $signed({tbl_price[order[m-1]][63],
                tbl_price[order[m-1]]});
            // divide by two, rounding toward zero
            h = s[64:1];
            if (s[64] && s[0])
                h = h + 64'd1;
            m_price = h;
            ca = tbl_conf[order[m-1]];
            m_conf = (m_conf & ca) + ((m_conf ^ ca) >> 1);
        end
        m_trading = 1'b1;
    endfunction

    function automatic result_t apply_item(item_t it);
        result_t r;
        int idx;
        outcome_t oc;
        oc = OUT_OK;
        if (it.kind == KIND_POST || it.kind == KIND_AGG) begin
            idx = find_id(it.id);
            if (idx < 0)
                oc = OUT_UNKNOWN;
            else begin
                if (it.slot > m_accum)
                    run_median(it.slot);
                if (it.kind == KIND_POST) begin
                    tbl_price[idx] = it.price;
                    tbl_conf[idx] = it.conf;
                    tbl_status[idx] = it.status;
                    tbl_slot[idx] = it.slot;
                end
            end
        end
        else if (it.id == 64'd0)
            oc = OUT_ZERO_ID;
        else if (it.kind == KIND_ADD) begin
            if (find_id(it.id) >= 0)
                oc = OUT_DUP;
            else if (tbl_count >= MaxPub)
                oc = OUT_FULL;
            else begin
                tbl_id[tbl_count] = it.id;
                tbl_price[tbl_count] = '0;
                tbl_conf[tbl_count] = '0;
                tbl_status[tbl_count] = '0;
                tbl_slot[tbl_count] = '0;
                tbl_count++;
            end
        end
        else begin
            idx = find_id(it.id);
            if (idx < 0)
                oc = OUT_UNKNOWN;
            else begin
                for (int k = idx; k + 1 < tbl_count; k++) begin
                    tbl_id[k] = tbl_id[k+1];
                    tbl_price[k] = tbl_price[k+1];
                    tbl_conf[k] = tbl_conf[k+1];
                    tbl_status[k] = tbl_status[k+1];
                    tbl_slot[k] = tbl_slot[k+1];
                end
                tbl_count--;
            end
        end
        r.outcome = oc;
        r.price = m_price;
        r.conf = m_conf;
        r.trading = m_trading;
        r.pub_slot = m_pub_slot;
        r.val_slot = m_valid_slot;
        r.count = tbl_count[5:0];
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // driver
    int push_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 1'b0;
            push_gap <= 0;
        end
        else begin
            if (push && !full)
                accepted_items <= accepted_items + 1;
            if (!push || !full) begin
                if (push_gap > 0) begin
                    push <= 1'b0;
                    push_gap <= push_gap - 1;
                end
                else if (pending_items.size() > 0) begin
                    item_t it;
                    it = pending_items.pop_front();
                    expected_results.push_back(apply_item(it));
                    push <= 1'b1;
                    kind <= it.kind;
                    publisher_id <= it.id;
                    quote_price <= it.price;
                    quote_conf <= it.conf;
                    quote_status <= it.status;
                    current_slot_in <= it.slot;
                    push_gap <= gap_len();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor
    int pop_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pop <= 1'b0;
            pop_gap <= 0;
        end
        else begin
            if (pop && !empty) begin
                result_t e;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer outcome=%0d", outcome);
                end
                else begin
                    e = expected_results.pop_front();
                    if (outcome !== e.outcome || agg_price !== e.price
                        || agg_conf !== e.conf || agg_trading !== e.trading
                        || agg_publish_slot !== e.pub_slot
                        || agg_valid_slot !== e.val_slot || publisher_count !== e.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: oc=%0d p=%0d c=%0d t=%0d ps=%0d vs=%0d n=%0d",
                                e.outcome, $signed(e.price), e.conf, e.trading,
                                e.pub_slot, e.val_slot, e.count);
                            $display("         got: oc=%0d p=%0d c=%0d t=%0d ps=%0d vs=%0d n=%0d",
                                outcome, agg_price, agg_conf, agg_trading,
                                agg_publish_slot, agg_valid_slot, publisher_count);
                        end
                    end
                end
            end
            if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else begin
                pop <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    pop_gap <= gap_len();
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_median_price_aggregator NOT OK");
            $finish;
        end
    end

    // id pool kept small so that posts and deletes mostly hit
    logic [63:0] id_pool [48];
    logic [63:0] cur_slot;

    function automatic item_t make_item(kind_t k, logic [63:0] id, logic [63:0] price,
        logic [63:0] conf, logic [7:0] status, logic [63:0] slot);
        item_t it;
        it.kind = k;
        it.id = id;
        it.price = price;
        it.conf = conf;
        it.status = status;
        it.slot = slot;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_results.size() > 0 || push)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_code(logic [7:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TRADING;
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        m_trading_code = v;
    endtask

    task automatic random_phase(int n, logic [7:0] code);
        logic [63:0] p;
        logic [7:0] st;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
                cur_slot = cur_slot + 64'd1;
            case ($urandom_range(0, 3))
                0: p = rand64();
                1: p = 64'(1000 + $urandom_range(0, 40));
                2: p = {$urandom_range(0, 1) ? 32'hffffffff : 32'h0, $urandom()};
                default: p = $urandom_range(0, 1) ? 64'h7fffffffffffffff
                                                 : 64'h8000000000000000;
            endcase
            st = ($urandom_range(0, 4) != 0) ? code : 8'($urandom());
            if (sel < 55)
                pending_items.push_back(make_item(KIND_POST, id_pool[$urandom_range(0, 47)],
                    p, rand64(), st, cur_slot));
            else if (sel < 65)
                pending_items.push_back(make_item(KIND_AGG, id_pool[$urandom_range(0, 47)],
                    rand64(), rand64(), 8'($urandom()),
                    $urandom_range(0, 9) == 0 ? rand64() : cur_slot));
            else if (sel < 82)
                pending_items.push_back(make_item(KIND_ADD, id_pool[$urandom_range(0, 47)],
                    rand64(), rand64(), 8'($urandom()), rand64()));
            else if (sel < 92)
                pending_items.push_back(make_item(KIND_DEL, id_pool[$urandom_range(0, 47)],
                    rand64(), rand64(), 8'($urandom()), rand64()));
            else
                pending_items.push_back(make_item(kind_t'($urandom_range(0, 3)),
                    $urandom_range(0, 1) ? 64'd0 : rand64(), rand64(), rand64(),
                    8'($urandom()), rand64()));
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        kind = KIND_POST;
        publisher_id = '0;
        quote_price = '0;
        quote_conf = '0;
        quote_status = '0;
        current_slot_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_TRADING;
        pwdata = '0;
        mismatches = 0;
        cycle_count = 0;
        accepted_items = 0;
        tbl_count = 0;
        m_accum = '0;
        m_valid_slot = '0;
        m_pub_slot = '0;
        m_price = '0;
        m_conf = '0;
        m_trading = 1'b0;
        m_trading_code = 8'd1;
        cur_slot = 64'd5;
        id_pool[0] = 64'hffffffffffffffff;
        id_pool[1] = 64'd1;
        for (int i = 2; i < 48; i++)
            id_pool[i] = rand64();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: errors, full table, an even median, extremes
        pending_items.push_back(make_item(KIND_ADD, 64'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(KIND_DEL, 64'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(KIND_POST, 64'd0, '0, '0, 8'd1, 64'd3));
        pending_items.push_back(make_item(KIND_AGG, 64'd7, '0, '0, 8'd1, 64'd3));
        pending_items.push_back(make_item(KIND_DEL, 64'd7, '0, '0, '0, '0));
        for (int i = 0; i < 33; i++)
            pending_items.push_back(make_item(KIND_ADD, id_pool[i], '0, '0, '0, '0));
        pending_items.push_back(make_item(KIND_ADD, id_pool[0], '0, '0, '0, '0));
        pending_items.push_back(make_item(KIND_POST, id_pool[0], 64'h7fffffffffffffff,
            64'hffffffffffffffff, 8'd1, 64'd4));
        pending_items.push_back(make_item(KIND_POST, id_pool[1], 64'h7ffffffffffffffd,
            64'hfffffffffffffffe, 8'd1, 64'd4));
        pending_items.push_back(make_item(KIND_POST, id_pool[2], 64'h8000000000000000,
            64'd3, 8'd1, 64'd4));
        pending_items.push_back(make_item(KIND_POST, id_pool[3], 64'hffffffffffffffff,
            64'd9, 8'd1, 64'd4));
        pending_items.push_back(make_item(KIND_POST, id_pool[4], 64'hffffffffffffffff,
            64'd2, 8'hff, 64'd4));
        pending_items.push_back(make_item(KIND_AGG, id_pool[0], '0, '0, '0, 64'd5));
        pending_items.push_back(make_item(KIND_AGG, id_pool[0], '0, '0, '0, 64'd5));
        pending_items.push_back(make_item(KIND_DEL, id_pool[1], '0, '0, '0, '0));
        pending_items.push_back(make_item(KIND_AGG, id_pool[0], '0, '0, '0, 64'd9));
        wait_idle();

        random_phase(140, 8'd1);
        wait_idle();
        write_code(8'd0);
        random_phase(140, 8'd0);
        wait_idle();
        write_code(8'hff);
        random_phase(140, 8'hff);
        // jump to the top of the slot range
        cur_slot = 64'hfffffffffffffff0;
        random_phase(40, 8'hff);
        wait_idle();

        if (mismatches == 0)
            $display("tb_median_price_aggregator OK");
        else
            $display("tb_median_price_aggregator NOT OK");
        $finish;
    end
endmodule
